[src/lbs_pkg.sv]
package lbs_pkg;

	// defaults for the top-level parameters
	localparam int MAX_MATRICES_DEF = 256;
	localparam int MAX_WEIGHTS_DEF  = 8;

	// field widths
	localparam int COORD_W  = 32;
	localparam int IDX_W    = 8;
	localparam int ESEL_W   = 4;
	localparam int WEIGHT_W = 18;
	localparam int CFG_W    = 4;

	// affine matrix: four rows by three columns
	localparam int ELEMS = 12;

	// influences per point, reset value and compare width
	localparam logic [CFG_W-1:0] WPP_RESET = CFG_W'(4);
	localparam int WPP_W = 5;

	// input beat layout
	localparam int S_DATA_W = 160;
	localparam int M_DATA_W = 3 * COORD_W;

	// command carried in tuser
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_INFL  = 1'b1;

	// depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_INFL  = 1'b1
	} op_kind_t;

	// one classified operation waiting for the back end
	typedef struct packed {
		op_kind_t              kind;
		logic                  mat_ok;
		logic [IDX_W-1:0]      mat_idx;
		logic [ESEL_W-1:0]     elem;
		logic [COORD_W-1:0]    value;
		logic [COORD_W-1:0]    px;
		logic [COORD_W-1:0]    py;
		logic [COORD_W-1:0]    pz;
		logic [WEIGHT_W-1:0]   weight;
	} op_t;

endpackage

[src/lbs_ram.sv]
module lbs_ram
	import lbs_pkg::*;
#(
	parameter int WIDTH = COORD_W,
	parameter int DEPTH = MAX_MATRICES_DEF
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[src/lbs_front.sv]
module lbs_front
	import lbs_pkg::*;
#(
	parameter int MAX_MATRICES = MAX_MATRICES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,
	input  logic                s_tuser,
	output op_t                 head,
	output logic                head_valid,
	input  logic                pop
);

	localparam int PTR_W = QUEUE_DEPTH > 1 ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	op_t              q_mem [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	op_t              op;
	logic             keep;
	logic             push;

	// unpack the beat and classify it
	always_comb begin
		op.kind    = (s_tuser == CMD_INFL) ? OP_INFL : OP_WRITE;
		op.px      = s_tdata[31:0];
		op.py      = s_tdata[63:32];
		op.pz      = s_tdata[95:64];
		op.mat_idx = s_tdata[103:96];
		op.elem    = s_tdata[107:104];
		op.value   = s_tdata[139:108];
		op.weight  = s_tdata[157:140];
		op.mat_ok  = 32'(op.mat_idx) < 32'(MAX_MATRICES);
		// writes to a missing matrix or element are dropped here
		keep = (op.kind == OP_INFL) || (op.mat_ok && (32'(op.elem) < 32'(ELEMS)));
	end

	assign s_tready   = count_q != CNT_W'(QUEUE_DEPTH);
	assign push       = s_tvalid && s_tready && keep;
	assign head       = q_mem[rd_ptr_q];
	assign head_valid = count_q != '0;

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= op;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

[src/lbs_back.sv]
module lbs_back
	import lbs_pkg::*;
#(
	parameter int MAX_MATRICES = MAX_MATRICES_DEF,
	parameter int MAX_WEIGHTS  = MAX_WEIGHTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic [CFG_W-1:0]    cfg_data,
	input  op_t                 head,
	input  logic                head_valid,
	output logic                pop,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata
);

	localparam int AW    = MAX_MATRICES > 1 ? $clog2(MAX_MATRICES) : 1;
	localparam int CNTW  = MAX_WEIGHTS > 1 ? $clog2(MAX_WEIGHTS) : 1;
	localparam int PROD_W = 2 * COORD_W;
	localparam int SH_W  = PROD_W - 16;
	localparam int T_W   = SH_W + 2;
	localparam int WP_W  = COORD_W + WEIGHT_W;
	localparam int SUM_W = 56;
	localparam int SS_W  = SUM_W - 16;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MUL  = 5'b00010,
		ST_WMUL = 5'b00100,
		ST_ACC  = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

	// saturate a transformed coordinate to 32 bits
	function automatic logic [COORD_W-1:0] sat_t(input logic [T_W-1:0] v);
		logic [COORD_W-1:0] r;
		if ((&v[T_W-1:COORD_W-1]) || !(|v[T_W-1:COORD_W-1])) begin
			r = v[COORD_W-1:0];
		end else begin
			r = v[T_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
		end
		return r;
	endfunction

	// saturate a shifted sum to 32 bits
	function automatic logic [COORD_W-1:0] sat_s(input logic [SS_W-1:0] v);
		logic [COORD_W-1:0] r;
		if ((&v[SS_W-1:COORD_W-1]) || !(|v[SS_W-1:COORD_W-1])) begin
			r = v[COORD_W-1:0];
		end else begin
			r = v[SS_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
		end
		return r;
	endfunction

	state_t                     state_q;
	logic [1:0]                 step_q;
	logic [CFG_W-1:0]           wpp_q;
	logic [CNTW-1:0]            count_q;
	logic                       mat_ok_q;
	logic [COORD_W-1:0]         p_q [3];
	logic [WEIGHT_W-1:0]        w_q;
	logic signed [PROD_W-1:0]   prod_q [3];
	logic signed [T_W-1:0]      t_q [3];
	logic signed [WP_W-1:0]     wprod_q [3];
	logic signed [SUM_W-1:0]    sum_q [3];
	logic [COORD_W-1:0]         out_q [3];
	logic                       out_valid_q;

	logic [IDX_W+AW-1:0]        addr_ext;
	logic [AW-1:0]              addr;
	logic [COORD_W-1:0]         rdata [ELEMS];
	logic                       rd_en;
	logic [COORD_W-1:0]         p_sel;
	logic [COORD_W-1:0]         m_sel [3];
	logic [COORD_W-1:0]         m_off [3];
	logic [WPP_W-1:0]           wpp_eff;
	logic [WPP_W-1:0]           cnt_next;
	logic                       last;
	logic                       out_free;

	assign addr_ext = {{AW{1'b0}}, head.mat_idx};
	assign addr     = addr_ext[AW-1:0];
	assign pop      = (state_q == ST_IDLE) && head_valid;
	assign rd_en    = pop && (head.kind == OP_INFL);
	assign out_free = !out_valid_q || m_tready;

	// one store per matrix element, all read together
	for (genvar e = 0; e < ELEMS; e++) begin : g_elem
		lbs_ram #(
			.WIDTH(COORD_W),
			.DEPTH(MAX_MATRICES)
		) u_ram (
			.clk   (clk),
			.we    (pop && (head.kind == OP_WRITE) && (head.elem == ESEL_W'(e))),
			.waddr (addr),
			.wdata (head.value),
			.re    (rd_en),
			.raddr (addr),
			.rdata (rdata[e])
		);
	end

	// pick the point coordinate and matrix row for this step
	always_comb begin
		case (step_q)
			2'd0:    p_sel = p_q[0];
			2'd1:    p_sel = p_q[1];
			default: p_sel = p_q[2];
		endcase
		for (int c = 0; c < 3; c++) begin
			case (step_q)
				2'd0:    m_sel[c] = rdata[c];
				2'd1:    m_sel[c] = rdata[3 + c];
				default: m_sel[c] = rdata[6 + c];
			endcase
			// a missing matrix reads as all zero
			if (!mat_ok_q) begin
				m_sel[c] = '0;
			end
			m_off[c] = mat_ok_q ? rdata[9 + c] : '0;
		end
	end

	// influence count against the clamped setting
	always_comb begin
		wpp_eff = WPP_W'(wpp_q);
		if (wpp_q == '0) begin
			wpp_eff = WPP_W'(1);
		end else if (WPP_W'(wpp_q) > WPP_W'(MAX_WEIGHTS)) begin
			wpp_eff = WPP_W'(MAX_WEIGHTS);
		end
		cnt_next = WPP_W'(count_q) + WPP_W'(1);
		last     = cnt_next >= wpp_eff;
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (rd_en) begin
			p_q[0]   <= head.px;
			p_q[1]   <= head.py;
			p_q[2]   <= head.pz;
			w_q      <= head.weight;
			mat_ok_q <= head.mat_ok;
		end
		if (state_q == ST_MUL) begin
			for (int c = 0; c < 3; c++) begin
				prod_q[c] <= $signed(p_sel) * $signed(m_sel[c]);
				if (step_q == 2'd0) begin
					t_q[c] <= {{(T_W-COORD_W){m_off[c][COORD_W-1]}}, m_off[c]};
				end else begin
					t_q[c] <= t_q[c] + {{(T_W-SH_W){prod_q[c][PROD_W-1]}},
						prod_q[c][PROD_W-1:16]};
				end
			end
		end
		if (state_q == ST_WMUL) begin
			for (int c = 0; c < 3; c++) begin
				wprod_q[c] <= $signed(sat_t(t_q[c])) * $signed(w_q);
			end
		end
		if ((state_q == ST_EMIT) && out_free) begin
			for (int c = 0; c < 3; c++) begin
				out_q[c] <= sat_s(sum_q[c][SUM_W-1:16]);
			end
		end
	end

	// sequencer, sums, count and output beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			wpp_q       <= WPP_RESET;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			for (int c = 0; c < 3; c++) begin
				sum_q[c] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				wpp_q <= cfg_data;
			end
			if (out_valid_q && m_tready && !((state_q == ST_EMIT) && out_free)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (rd_en) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3) begin
						state_q <= ST_WMUL;
					end
				end
				ST_WMUL: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					for (int c = 0; c < 3; c++) begin
						sum_q[c] <= sum_q[c] + {{(SUM_W-WP_W){wprod_q[c][WP_W-1]}}, wprod_q[c]};
					end
					if (last) begin
						count_q <= '0;
						state_q <= ST_EMIT;
					end else begin
						count_q <= cnt_next[CNTW-1:0];
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						for (int c = 0; c < 3; c++) begin
							sum_q[c] <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q[2], out_q[1], out_q[0]};

endmodule

[src/linear_blend_point_skinning.sv]
// channel   dir  handshake                content
// s_        in   s_tvalid / s_tready      one command beat: tuser cmd, tdata operands
// m_        out  m_tvalid / m_tready      one deformed position per point
// cfg_      in   cfg_valid / cfg_ready    influences per point, 4 bits
//
// a matrix element write is stored as the back end pops it; an influence
// takes a store read, four multiply-add steps, a weight multiply and an
// accumulate; the last influence of a point also loads the output register.
// the two-entry queue lets the front take beats while the back end works.
// arst_n clears the queue, sums, count and output; the matrix store is not
// cleared and must be written before use. m_tready low stalls only the emit.
module linear_blend_point_skinning
	import lbs_pkg::*;
#(
	parameter int MAX_MATRICES = MAX_MATRICES_DEF,
	parameter int MAX_WEIGHTS  = MAX_WEIGHTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// point_x[31:0] point_y[63:32] point_z[95:64] matrix_index[103:96]
	// element_select[107:104] element_value[139:108] weight[157:140], zero pad
	input  logic [S_DATA_W-1:0] s_tdata,
	// cmd
	input  logic                s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	// out_x[31:0] out_y[63:32] out_z[95:64]
	output logic [M_DATA_W-1:0] m_tdata,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CFG_W-1:0]    cfg_data
);

	op_t  head;
	logic head_valid;
	logic pop;

	// the register is always writable
	assign cfg_ready = 1'b1;

	lbs_front #(
		.MAX_MATRICES(MAX_MATRICES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop)
	);

	lbs_back #(
		.MAX_MATRICES(MAX_MATRICES),
		.MAX_WEIGHTS (MAX_WEIGHTS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule

[dv/lbs_skin_checker.sv]
module lbs_skin_checker
	import lbs_pkg::*;
#(
	parameter int MAX_MATRICES = MAX_MATRICES_DEF,
	parameter int MAX_WEIGHTS  = MAX_WEIGHTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tready,
	// point_x point_y point_z matrix_index element_select element_value weight, zero pad
	input  logic [S_DATA_W-1:0] s_tdata,
	// cmd
	input  logic                s_tuser,
	input  logic                m_tvalid,
	input  logic                m_tready,
	// out_x out_y out_z
	input  logic [M_DATA_W-1:0] m_tdata,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [CFG_W-1:0]    cfg_data,
	output int                  fails,
	output int                  backlog,
	output int                  points_out
);
	timeunit 1ns;
	timeprecision 1ps;

	// field offsets inside the input beat
	localparam int IDX_LO  = 3 * COORD_W;
	localparam int ESEL_LO = IDX_LO + IDX_W;
	localparam int VAL_LO  = ESEL_LO + ESEL_W;
	localparam int WT_LO   = VAL_LO + COORD_W;

	// predicted block state
	logic signed [COORD_W-1:0] matrix_bank [MAX_MATRICES*ELEMS];
	longint                    acc_x, acc_y, acc_z;
	int unsigned               infl_taken;
	logic [CFG_W-1:0]          wpp_reg;

	// deformed positions still to arrive, oldest first
	logic [M_DATA_W-1:0]       pending_pos [$];
	logic [M_DATA_W-1:0]       want;
	int                        err_count;
	int                        emitted;
	string                     axis_tag = "xyz";

	function automatic longint clamp32(input longint v);
		if (v > longint'(32'sh7fffffff))
			return longint'(32'sh7fffffff);
		if (v < -longint'(32'sh7fffffff) - 1)
			return -longint'(32'sh7fffffff) - 1;
		return v;
	endfunction

	// one axis of the row vector (x y z 1) times the affine bind matrix
	function automatic longint skin_axis(input longint px, input longint py, input longint pz,
			input int unsigned mi, input int unsigned c);
		longint t, m0, m1, m2;
		if (mi >= MAX_MATRICES)
			return 0;
		t  = matrix_bank[mi*ELEMS + 9 + c];
		m0 = matrix_bank[mi*ELEMS + c];
		m1 = matrix_bank[mi*ELEMS + 3 + c];
		m2 = matrix_bank[mi*ELEMS + 6 + c];
		t += (px * m0) >>> 16;
		t += (py * m1) >>> 16;
		t += (pz * m2) >>> 16;
		return clamp32(t);
	endfunction

	// apply one accepted input beat to the predicted state
	task automatic take_beat(input logic [S_DATA_W-1:0] d, input logic cmd);
		int unsigned mi, esel, eff;
		longint px, py, pz, w;
		logic [M_DATA_W-1:0] pos;
		mi   = d[IDX_LO +: IDX_W];
		esel = d[ESEL_LO +: ESEL_W];
		if (cmd == CMD_WRITE) begin
			if (mi < MAX_MATRICES && esel < ELEMS)
				matrix_bank[mi*ELEMS + esel] = d[VAL_LO +: COORD_W];
		end else begin
			px = longint'(signed'(d[0 +: COORD_W]));
			py = longint'(signed'(d[COORD_W +: COORD_W]));
			pz = longint'(signed'(d[2*COORD_W +: COORD_W]));
			w  = longint'(signed'(d[WT_LO +: WEIGHT_W]));
			acc_x += skin_axis(px, py, pz, mi, 0) * w;
			acc_y += skin_axis(px, py, pz, mi, 1) * w;
			acc_z += skin_axis(px, py, pz, mi, 2) * w;
			// out-of-range settings clamp to the nearest legal count
			if (wpp_reg == 0)
				eff = 1;
			else if (wpp_reg > MAX_WEIGHTS)
				eff = MAX_WEIGHTS;
			else
				eff = wpp_reg;
			if (infl_taken + 1 < eff) begin
				infl_taken++;
			end else begin
				pos[0 +: COORD_W]         = COORD_W'(clamp32(acc_x >>> 16));
				pos[COORD_W +: COORD_W]   = COORD_W'(clamp32(acc_y >>> 16));
				pos[2*COORD_W +: COORD_W] = COORD_W'(clamp32(acc_z >>> 16));
				pending_pos.push_back(pos);
				acc_x = 0;
				acc_y = 0;
				acc_z = 0;
				infl_taken = 0;
			end
		end
	endtask

	// watch all three channels; output beats are matched before new input is applied
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_x = 0;
			acc_y = 0;
			acc_z = 0;
			infl_taken = 0;
			wpp_reg = WPP_RESET;
			pending_pos.delete();
			err_count = 0;
			emitted = 0;
			fails <= 0;
			backlog <= 0;
			points_out <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_pos.size() == 0) begin
					$display("%0t: deformed point %h arrived with none outstanding",
						$time, m_tdata);
					err_count++;
				end else begin
					want = pending_pos.pop_front();
					for (int i = 0; i < 3; i++) begin
						if (m_tdata[i*COORD_W +: COORD_W] !== want[i*COORD_W +: COORD_W]) begin
							$display("%0t: out_%c expected %h got %h", $time, axis_tag[i],
								want[i*COORD_W +: COORD_W], m_tdata[i*COORD_W +: COORD_W]);
							err_count++;
						end
					end
					emitted++;
				end
			end
			if (cfg_valid && cfg_ready)
				wpp_reg = cfg_data;
			if (s_tvalid && s_tready)
				take_beat(s_tdata, s_tuser);
			fails <= err_count;
			backlog <= pending_pos.size();
			points_out <= emitted;
		end
	end

endmodule

[dv/tb_linear_blend_point_skinning.sv]
module tb_linear_blend_point_skinning
	import lbs_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEMS_TARGET = 400;
	localparam int QUIET_CYCLES = 48;
	localparam int HOLD_CYCLES  = 600;
	localparam int CYCLE_LIMIT  = 400000;

	// how the elements of a freshly loaded bind matrix are chosen
	typedef enum int {
		STYLE_IDENT,
		STYLE_JITTER,
		STYLE_WILD,
		STYLE_EXTREME
	} mat_style_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	// point_x point_y point_z matrix_index element_select element_value weight, zero pad
	logic [S_DATA_W-1:0] s_tdata;
	// cmd
	logic                s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	// out_x out_y out_z
	logic [M_DATA_W-1:0] m_tdata;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CFG_W-1:0]    cfg_data;

	int                  fails;
	int                  backlog;
	int                  points_out;
	int                  cycle_count = 0;
	bit                  hold_req = 0;

	// sender bookkeeping
	int                  burst_left = 0;
	int                  cur_wpp = 4;
	int                  items_sent = 0;
	int                  infl_sent = 0;
	int                  writes_sent = 0;
	int                  cfg_writes = 0;
	bit [ELEMS-1:0]      loaded_elems [256];
	bit                  mat_ready [256];
	logic [IDX_W-1:0]    ready_mats [$];

	linear_blend_point_skinning DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	lbs_skin_checker u_skin_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.fails      (fails),
		.backlog    (backlog),
		.points_out (points_out)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("run exceeded %0d cycles with %0d points outstanding", CYCLE_LIMIT, backlog);
			$display("FAIL");
			$finish;
		end
	end

	// output side: segments of steady, random and sparse ready, plus one long hold-off
	initial begin
		int hold_left, seg_len, mode;
		hold_left = 0;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			seg_len = $urandom_range(16, 96);
			mode = $urandom_range(0, 2);
			repeat (seg_len) begin
				@(posedge clk);
				if (hold_req) begin
					hold_req = 0;
					hold_left = HOLD_CYCLES;
				end
				if (hold_left > 0) begin
					hold_left--;
					m_tready <= 1'b0;
				end else begin
					case (mode)
						0: m_tready <= 1'b1;
						1: m_tready <= $urandom_range(0, 1);
						default: m_tready <= (cycle_count % 4 == 0);
					endcase
				end
			end
		end
	end

	function automatic logic [COORD_W-1:0] signed_span(input int unsigned r);
		return COORD_W'($urandom_range(0, 2 * r)) - COORD_W'(r);
	endfunction

	function automatic logic [COORD_W-1:0] pick_word();
		case ($urandom_range(0, 6))
			0: return $urandom;
			1: return 32'h7fffffff;
			2: return 32'h80000000;
			3: return '0;
			4: return signed_span(1 << 24);
			default: return signed_span(1 << 20);
		endcase
	endfunction

	function automatic logic [WEIGHT_W-1:0] pick_weight();
		case ($urandom_range(0, 6))
			0: return WEIGHT_W'($urandom);
			1: return 18'h1ffff;
			2: return 18'h20000;
			3: return '0;
			4: return 18'h04000;
			default: return WEIGHT_W'(32'h10000 + $urandom_range(0, 32'h8000) - 32'h4000);
		endcase
	endfunction

	function automatic logic [COORD_W-1:0] mat_word(input mat_style_t style, input int e);
		int r, c;
		r = e / 3;
		c = e % 3;
		case (style)
			STYLE_IDENT:
				return (r == 3) ? signed_span(1 << 20) : ((r == c) ? 32'h10000 : 32'h0);
			STYLE_JITTER:
				return (r == 3) ? signed_span(1 << 22) :
					((r == c) ? 32'h10000 + signed_span(1 << 14) : signed_span(1 << 15));
			STYLE_WILD:
				return pick_word();
			default:
				return e[0] ? 32'h80000000 : 32'h7fffffff;
		endcase
	endfunction

	function automatic logic [S_DATA_W-1:0] pack_beat(input logic [COORD_W-1:0] px,
			input logic [COORD_W-1:0] py, input logic [COORD_W-1:0] pz,
			input logic [IDX_W-1:0] mi, input logic [ESEL_W-1:0] esel,
			input logic [COORD_W-1:0] ev, input logic [WEIGHT_W-1:0] w);
		logic [S_DATA_W-1:0] d;
		d = '0;
		d[3*COORD_W+IDX_W+ESEL_W+COORD_W+WEIGHT_W-1:0] = {w, ev, esel, mi, pz, py, px};
		return d;
	endfunction

	// offer one beat; valid stays high across a burst, bursts are split by gaps
	task automatic send_beat(input logic cmd, input logic [S_DATA_W-1:0] d);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 12);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= d;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		burst_left--;
	endtask

	task automatic send_write(input logic [IDX_W-1:0] mi, input logic [ESEL_W-1:0] esel,
			input logic [COORD_W-1:0] val);
		send_beat(CMD_WRITE, pack_beat($urandom, $urandom, $urandom, mi, esel, val,
			WEIGHT_W'($urandom)));
		if (esel < ELEMS) begin
			items_sent++;
			writes_sent++;
			loaded_elems[mi][esel] = 1'b1;
			if (&loaded_elems[mi] && !mat_ready[mi]) begin
				mat_ready[mi] = 1'b1;
				ready_mats.push_back(mi);
			end
		end
	endtask

	task automatic send_infl(input logic [IDX_W-1:0] mi, input logic [COORD_W-1:0] px,
			input logic [COORD_W-1:0] py, input logic [COORD_W-1:0] pz,
			input logic [WEIGHT_W-1:0] w);
		send_beat(CMD_INFL, pack_beat(px, py, pz, mi, ESEL_W'($urandom), $urandom, w));
		items_sent++;
		infl_sent++;
	endtask

	// all twelve elements, visited in a scrambled order
	task automatic load_matrix(input logic [IDX_W-1:0] mi, input mat_style_t style);
		int first, stride, e;
		first = $urandom_range(0, ELEMS - 1);
		case ($urandom_range(0, 3))
			0: stride = 1;
			1: stride = 5;
			2: stride = 7;
			default: stride = 11;
		endcase
		for (int k = 0; k < ELEMS; k++) begin
			e = (first + k * stride) % ELEMS;
			send_write(mi, ESEL_W'(e), mat_word(style, e));
		end
	endtask

	// n influences with random points, each on some fully loaded matrix
	task automatic send_point(input int n);
		repeat (n)
			send_infl(ready_mats[$urandom_range(0, ready_mats.size() - 1)], pick_word(),
				pick_word(), pick_word(), pick_weight());
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (backlog != 0) @(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic set_wpp(input logic [CFG_W-1:0] v);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		cfg_writes++;
		if (v == 0)
			cur_wpp = 1;
		else if (v > MAX_WEIGHTS_DEF)
			cur_wpp = MAX_WEIGHTS_DEF;
		else
			cur_wpp = v;
	endtask

	initial begin
		int next_cfg_at;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_WRITE;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// identity with a translation, and a matrix of full-scale words
		load_matrix(8'd0, STYLE_IDENT);
		load_matrix(8'd255, STYLE_EXTREME);
		// element selects past the last row must not disturb the identity
		send_write(8'd0, ESEL_W'(12), 32'h7fffffff);
		send_write(8'd0, ESEL_W'(15), 32'h80000000);

		// plain point through the identity at the reset count of four
		repeat (4)
			send_infl(8'd0, 32'h00010000, 32'h00020000, 32'hfffd0000, 18'h04000);
		// transform and sum saturation with extreme weights
		send_infl(8'd255, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 18'h1ffff);
		send_infl(8'd255, 32'h80000000, 32'h7fffffff, 32'h80000000, 18'h20000);
		send_infl(8'd255, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 18'h00000);
		send_infl(8'd255, 32'h80000000, 32'h80000000, 32'h80000000, 18'h1ffff);

		// zero setting acts as one influence per point
		set_wpp(4'd0);
		send_infl(8'd255, 32'h0, 32'h0, 32'h0, 18'h20000);
		// setting above the maximum acts as the maximum
		set_wpp(4'd15);
		repeat (8)
			send_infl(8'd0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 18'h1ffff);
		// lowering the count part way through a point emits on the next influence
		set_wpp(4'd4);
		send_point(2);
		set_wpp(4'd2);
		send_point(1);
		set_wpp(4'd8);
		send_point(8);

		// output held off while single-influence points pile up behind it
		set_wpp(4'd1);
		hold_req = 1;
		send_point(24);

		// random phase: mostly loads and whole points, some noise and broken points
		next_cfg_at = items_sent + $urandom_range(30, 70);
		while (items_sent < ITEMS_TARGET) begin
			if (items_sent >= next_cfg_at) begin
				case ($urandom_range(0, 5))
					0: set_wpp(4'd0);
					1: set_wpp(4'd15);
					2: set_wpp(CFG_W'($urandom_range(9, 14)));
					default: set_wpp(CFG_W'($urandom_range(1, 8)));
				endcase
				next_cfg_at = items_sent + $urandom_range(30, 70);
			end
			case ($urandom_range(0, 9))
				0, 1: load_matrix(IDX_W'($urandom),
					($urandom_range(0, 3) == 0) ? STYLE_WILD : STYLE_JITTER);
				2: repeat ($urandom_range(1, 4))
					send_write(IDX_W'($urandom), ESEL_W'($urandom), pick_word());
				3: send_point($urandom_range(1, cur_wpp));
				default: send_point(cur_wpp);
			endcase
		end

		settle();
		$display("%0d influences and %0d matrix element writes sent across %0d setting changes",
			infl_sent, writes_sent, cfg_writes);
		$display("%0d deformed points compared, %0d matrices loaded", points_out,
			ready_mats.size());
		if (fails == 0 && backlog == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
